>>> sv/frdf_pkg.sv
// Package for the flood relay duplicate filter: widths, codes, register map
// and the structs shared by the top level, the id cache and the classifier.
// No dependencies.
package frdf_pkg;

  localparam int unsigned IdW      = 32;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned VerdictW = 4;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 8;

  typedef enum logic [VerdictW-1:0] {
    V_SHORT_HDR   = 4'd0,
    V_DUPLICATE   = 4'd1,
    V_DATA_OK     = 4'd2,
    V_DATA_BADCRC = 4'd3,
    V_DATA_SHORT  = 4'd4,
    V_ADV_DELIVER = 4'd5,
    V_ADV_IGNORED = 4'd6,
    V_ADV_SHORT   = 4'd7,
    V_CHK_DELIVER = 4'd8,
    V_CHK_IGNORED = 4'd9,
    V_CHK_SHORT   = 4'd10,
    V_UNKNOWN     = 4'd11
  } verdict_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEADER_BYTES    = 8'd0,
    CFG_DATA_TYPE_CODE  = 8'd1,
    CFG_ADV_TYPE_CODE   = 8'd2,
    CFG_CHUNK_TYPE_CODE = 8'd3,
    CFG_DATA_MIN_BODY   = 8'd4,
    CFG_ADV_MIN_BODY    = 8'd5,
    CFG_CHUNK_MIN_BODY  = 8'd6,
    CFG_NODE_IS_GATEWAY = 8'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [ByteW-1:0] header_bytes;
    logic [ByteW-1:0] data_type_code;
    logic [ByteW-1:0] adv_type_code;
    logic [ByteW-1:0] chunk_type_code;
    logic [ByteW-1:0] data_min_body;
    logic [ByteW-1:0] adv_min_body;
    logic [ByteW-1:0] chunk_min_body;
    logic             node_is_gateway;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    header_bytes:    8'd8,
    data_type_code:  8'd1,
    adv_type_code:   8'd2,
    chunk_type_code: 8'd3,
    data_min_body:   8'd0,
    adv_min_body:    8'd0,
    chunk_min_body:  8'd0,
    node_is_gateway: 1'b0
  };

  typedef struct packed {
    logic [IdW-1:0]   message_id;
    logic [ByteW-1:0] message_type;
    logic [ByteW-1:0] hops_left;
    logic [ByteW-1:0] packet_length;
    logic             frame_crc_good;
    logic             update_broadcasting;
  } item_t;

  typedef struct packed {
    verdict_e         verdict;
    logic             relay;
    logic [ByteW-1:0] relay_hops;
  } res_t;

  typedef struct packed {
    logic           start;
    logic [IdW-1:0] id;
  } cache_req_t;

  typedef struct packed {
    logic done;
    logic hit;
  } cache_rsp_t;

endpackage

>>> sv/frdf_if.sv
// Handshake channels of the flood relay duplicate filter: packet headers in,
// verdicts out, and the register write channel. Depends on frdf_pkg.
interface frdf_in_if;
  import frdf_pkg::*;
  logic             valid;
  logic             ready;
  logic [IdW-1:0]   message_id;
  logic [ByteW-1:0] message_type;
  logic [ByteW-1:0] hops_left;
  logic [ByteW-1:0] packet_length;
  logic             frame_crc_good;
  logic             update_broadcasting;

  modport source (
    output valid, message_id, message_type, hops_left, packet_length,
           frame_crc_good, update_broadcasting,
    input  ready
  );
  modport sink (
    input  valid, message_id, message_type, hops_left, packet_length,
           frame_crc_good, update_broadcasting,
    output ready
  );
endinterface

interface frdf_out_if;
  import frdf_pkg::*;
  logic                valid;
  logic                ready;
  logic [VerdictW-1:0] verdict;
  logic                relay;
  logic [ByteW-1:0]    relay_hops;

  modport source (output valid, verdict, relay, relay_hops, input ready);
  modport sink (input valid, verdict, relay, relay_hops, output ready);
endinterface

interface frdf_cfg_if;
  import frdf_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> sv/frdf_id_cache.sv
// FIFO cache of recent message ids in a one-port-read, one-port-write memory.
// Scans the filled entries with a pipelined read; records the id on a miss.
// Depends on frdf_pkg.
module frdf_id_cache #(
  parameter int unsigned Depth = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  frdf_pkg::cache_req_t req_i,
  output frdf_pkg::cache_rsp_t rsp_o
);
  import frdf_pkg::*;

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);
  localparam logic [IdxW-1:0] LastSlot = IdxW'(Depth - 1);

  typedef enum logic [1:0] {
    C_IDLE = 2'b01,
    C_SCAN = 2'b10
  } cache_state_e;

  cache_state_e    state_q, state_d;
  logic [IdW-1:0]  mem_q [Depth];
  logic [IdW-1:0]  id_q;
  logic [IdW-1:0]  rdata_q;
  logic [CntW-1:0] fill_q, fill_d;
  logic [CntW-1:0] iss_q, iss_d;
  logic [IdxW-1:0] oldest_q, oldest_d;
  logic            cmp_vld_q, cmp_vld_d;
  logic            issue, match, miss_wr, full;
  logic [IdxW-1:0] wr_addr;

  always_comb begin
    issue   = (state_q == C_SCAN) && (iss_q < fill_q);
    match   = (state_q == C_SCAN) && cmp_vld_q && (rdata_q == id_q);
    miss_wr = (state_q == C_SCAN) && !match && !issue;
    full    = (fill_q == DepthCnt);
    wr_addr = full ? oldest_q : fill_q[IdxW-1:0];

    fill_d   = fill_q;
    oldest_d = oldest_q;
    if (miss_wr) begin
      if (!full) begin
        fill_d = fill_q + 1'b1;
      end else begin
        oldest_d = (oldest_q == LastSlot) ? '0 : oldest_q + 1'b1;
      end
    end

    state_d   = state_q;
    iss_d     = iss_q;
    cmp_vld_d = 1'b0;
    case (state_q)
      C_IDLE: begin
        if (req_i.start) begin
          state_d = C_SCAN;
          iss_d   = '0;
        end
      end
      C_SCAN: begin
        cmp_vld_d = issue;
        if (issue) begin
          iss_d = iss_q + 1'b1;
        end
        if (match || miss_wr) begin
          state_d   = C_IDLE;
          cmp_vld_d = 1'b0;
        end
      end
      default: begin
        state_d = C_IDLE;
      end
    endcase

    rsp_o.done = match || miss_wr;
    rsp_o.hit  = match;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= C_IDLE;
      fill_q    <= '0;
      oldest_q  <= '0;
      iss_q     <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      oldest_q  <= oldest_d;
      iss_q     <= iss_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == C_IDLE) && req_i.start) begin
      id_q <= req_i.id;
    end
  end

  always_ff @(posedge clk_i) begin
    if (miss_wr) begin
      mem_q[wr_addr] <= id_q;
    end
    if (issue) begin
      rdata_q <= mem_q[iss_q[IdxW-1:0]];
    end
  end

endmodule

>>> sv/frdf_classify.sv
// Verdict and relay decision for a packet that passed the duplicate check.
// Pure logic on the held header and the register set. Depends on frdf_pkg.
module frdf_classify (
  input  frdf_pkg::item_t item_i,
  input  frdf_pkg::cfg_t  cfg_i,
  output frdf_pkg::res_t  res_o
);
  import frdf_pkg::*;

  logic [ByteW-1:0] body;
  logic             ignore_upd;

  always_comb begin
    body       = item_i.packet_length - cfg_i.header_bytes;
    ignore_upd = cfg_i.node_is_gateway && item_i.update_broadcasting;

    if (item_i.message_type == cfg_i.data_type_code) begin
      if (body < cfg_i.data_min_body) begin
        res_o.verdict = V_DATA_SHORT;
      end else begin
        res_o.verdict = item_i.frame_crc_good ? V_DATA_OK : V_DATA_BADCRC;
      end
    end else if (item_i.message_type == cfg_i.adv_type_code) begin
      if (body < cfg_i.adv_min_body) begin
        res_o.verdict = V_ADV_SHORT;
      end else begin
        res_o.verdict = ignore_upd ? V_ADV_IGNORED : V_ADV_DELIVER;
      end
    end else if (item_i.message_type == cfg_i.chunk_type_code) begin
      if (body < cfg_i.chunk_min_body) begin
        res_o.verdict = V_CHK_SHORT;
      end else begin
        res_o.verdict = ignore_upd ? V_CHK_IGNORED : V_CHK_DELIVER;
      end
    end else begin
      res_o.verdict = V_UNKNOWN;
    end

    res_o.relay      = (item_i.hops_left != '0);
    res_o.relay_hops = res_o.relay ? item_i.hops_left - 1'b1 : '0;
  end

endmodule

>>> sv/flood_relay_duplicate_filter.sv
// Flood-mesh receive filter: short-header drop, duplicate id suppression and
// hop-count relay. Depends on frdf_pkg, frdf_if, frdf_id_cache, frdf_classify.
//
//   channel  port   dir  fields
//   header   in_i   in   message_id, message_type, hops_left, packet_length,
//                        frame_crc_good, update_broadcasting
//   result   out_o  out  verdict, relay, relay_hops
//   regs     cfg_i  in   index, data (register write, always ready)
//
// One header at a time. A short header's result passes through res_q into the
// output register on out_o, and in_i is ready again once it is loaded there. Any
// other header first waits on the one-entry-per-cycle id memory read over the
// fill cached ids (fill being up to CACHE_DEPTH); a hit ends the scan early.
// A result waiting on out_o sits in the output register while the next header is
// scanned; a second result then holds in_i off until out_o takes the first.
// rst_ni clears registers to their defaults and empties the cache.
module flood_relay_duplicate_filter #(
  parameter int unsigned CACHE_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  frdf_in_if.sink    in_i,
  frdf_out_if.source out_o,
  frdf_cfg_if.sink   cfg_i
);
  import frdf_pkg::*;

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_WAIT = 3'b010,
    T_DONE = 3'b100
  } top_state_e;

  top_state_e state_q, state_d;
  cfg_t       cfg_q, cfg_d;
  item_t      item_q;
  res_t       res_q, res_d;
  res_t       out_res_q;
  res_t       class_res;
  logic       out_valid_q, out_valid_d;
  logic       in_acc, in_short, out_load;
  cache_req_t cache_req;
  cache_rsp_t cache_rsp;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_HEADER_BYTES:    cfg_d.header_bytes    = cfg_i.data;
        CFG_DATA_TYPE_CODE:  cfg_d.data_type_code  = cfg_i.data;
        CFG_ADV_TYPE_CODE:   cfg_d.adv_type_code   = cfg_i.data;
        CFG_CHUNK_TYPE_CODE: cfg_d.chunk_type_code = cfg_i.data;
        CFG_DATA_MIN_BODY:   cfg_d.data_min_body   = cfg_i.data;
        CFG_ADV_MIN_BODY:    cfg_d.adv_min_body    = cfg_i.data;
        CFG_CHUNK_MIN_BODY:  cfg_d.chunk_min_body  = cfg_i.data;
        CFG_NODE_IS_GATEWAY: cfg_d.node_is_gateway = cfg_i.data[0];
        default: ;
      endcase
    end
  end

  frdf_id_cache #(
    .Depth(CACHE_DEPTH)
  ) u_cache (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (cache_req),
    .rsp_o (cache_rsp)
  );

  frdf_classify u_classify (
    .item_i(item_q),
    .cfg_i (cfg_q),
    .res_o (class_res)
  );

  assign in_i.ready = (state_q == T_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign in_short   = (in_i.packet_length < cfg_q.header_bytes);
  assign out_load   = (state_q == T_DONE) && (!out_valid_q || out_o.ready);

  always_comb begin
    cache_req.start = in_acc && !in_short;
    cache_req.id    = in_i.message_id;

    state_d = state_q;
    res_d   = res_q;
    case (state_q)
      T_IDLE: begin
        if (in_acc) begin
          if (in_short) begin
            res_d   = '{verdict: V_SHORT_HDR, relay: 1'b0, relay_hops: '0};
            state_d = T_DONE;
          end else begin
            state_d = T_WAIT;
          end
        end
      end
      T_WAIT: begin
        if (cache_rsp.done) begin
          if (cache_rsp.hit) begin
            res_d = '{verdict: V_DUPLICATE, relay: 1'b0, relay_hops: '0};
          end else begin
            res_d = class_res;
          end
          state_d = T_DONE;
        end
      end
      T_DONE: begin
        if (out_load) begin
          state_d = T_IDLE;
        end
      end
      default: begin
        state_d = T_IDLE;
      end
    endcase

    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      cfg_q       <= CfgReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= '{
        message_id:          in_i.message_id,
        message_type:        in_i.message_type,
        hops_left:           in_i.hops_left,
        packet_length:       in_i.packet_length,
        frame_crc_good:      in_i.frame_crc_good,
        update_broadcasting: in_i.update_broadcasting
      };
    end
    res_q <= res_d;
    if (out_load) begin
      out_res_q <= res_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.verdict    = out_res_q.verdict;
  assign out_o.relay      = out_res_q.relay;
  assign out_o.relay_hops = out_res_q.relay_hops;

endmodule
